### hdl/qpst_pkg.sv
// Shared types, widths and constants of the quadrature position and speed tracker.
`timescale 1ns / 1ps
`default_nettype none
package qpst_pkg;

	// Field widths
	localparam int POS_W  = 12;
	localparam int CPR_W  = 13;
	localparam int ARM_W  = 12;
	localparam int TPS_W  = 27;
	localparam int TIME_W = 32;
	localparam int REV_W  = 16;
	localparam int SPD_W  = 24;
	localparam int OP_W   = 2;

	// Averaging ring (power of two depth, 2..64)
	localparam int AVG_DEPTH = 8;
	localparam int AVG_LOG2  = $clog2(AVG_DEPTH);
	localparam int RIDX_W    = AVG_LOG2;
	localparam int SUM_W     = SPD_W + AVG_LOG2;

	// Speed divider: numerator is ticks_per_second in Q.8
	localparam int NUM_W  = TPS_W + 8;
	localparam int DCNT_W = $clog2(NUM_W);

	// Wrap count clamp
	localparam logic [CPR_W-1:0] CPR_MIN = 13'd2;
	localparam logic [CPR_W-1:0] CPR_MAX = 13'd4096;

	// Speed saturation limits
	localparam logic signed [SPD_W-1:0] SPD_MAX = 24'sh7FFFFF;
	localparam logic signed [SPD_W-1:0] SPD_MIN = 24'sh800000;

	// Register reset values
	localparam logic [CPR_W-1:0]  CPR_RST  = 13'd468;
	localparam logic [ARM_W-1:0]  ARM_RST  = 12'd233;
	localparam logic [TPS_W-1:0]  TPS_RST  = 27'd1000000;
	localparam logic [TIME_W-1:0] IDLE_RST = 32'd1000000;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CPR  = 2'd0,
		CFG_ARM  = 2'd1,
		CFG_TPS  = 2'd2,
		CFG_IDLE = 2'd3
	} cfg_idx_t;

	// Operation codes on the input
	localparam logic [OP_W-1:0] OP_EDGE  = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Queues between the parts
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef enum logic [1:0] {
		K_EDGE,
		K_QUERY,
		K_CLEAR
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} core_state_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic              channel;
		logic              level;
		logic [TIME_W-1:0] timestamp;
	} cmd_t;

	typedef struct packed {
		logic [CPR_W-1:0]  cpr;
		logic [ARM_W-1:0]  arm;
		logic [TPS_W-1:0]  tps;
		logic [TIME_W-1:0] idle;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]        position;
		logic                    direction;
		logic signed [REV_W-1:0] rev_count;
		logic signed [SPD_W-1:0] speed;
		logic signed [SPD_W-1:0] avg_speed;
		logic                    moving;
	} res_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  dividend;
		logic [TIME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage
`default_nettype wire

### hdl/qpst_front.sv
// Front part: accepts input words, classifies them and holds them in a short command queue.
`timescale 1ns / 1ps
`default_nettype none
module qpst_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [qpst_pkg::OP_W-1:0]  operation,
	input  wire logic                       channel,
	input  wire logic                       level,
	input  wire logic [qpst_pkg::TIME_W-1:0] timestamp,
	output logic                            full,
	output logic                            cmd_valid,
	output qpst_pkg::cmd_t                  cmd,
	input  wire logic                       cmd_pop
);

	qpst_pkg::cmd_t                   ent_q [qpst_pkg::QDEPTH];
	logic [qpst_pkg::QPTR_W-1:0]      wr_q;
	logic [qpst_pkg::QPTR_W-1:0]      rd_q;
	logic [qpst_pkg::QCNT_W-1:0]      cnt_q;
	qpst_pkg::cmd_t                   cmd_in;
	logic                             do_wr;
	logic                             do_rd;

	// Classify the incoming word; the unused code acts as a query
	always_comb begin
		cmd_in.channel   = channel;
		cmd_in.level     = level;
		cmd_in.timestamp = timestamp;
		unique case (operation)
			qpst_pkg::OP_EDGE:  cmd_in.kind = qpst_pkg::K_EDGE;
			qpst_pkg::OP_CLEAR: cmd_in.kind = qpst_pkg::K_CLEAR;
			default:            cmd_in.kind = qpst_pkg::K_QUERY;
		endcase
	end

	// Queue status
	assign full      = (cnt_q == qpst_pkg::QCNT_W'(qpst_pkg::QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = ent_q[rd_q];
	assign do_wr     = push && !full;
	assign do_rd     = cmd_pop && cmd_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= (wr_q == qpst_pkg::QPTR_W'(qpst_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_rd) begin
				rd_q <= (rd_q == qpst_pkg::QPTR_W'(qpst_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_q] <= cmd_in;
		end
	end

endmodule
`default_nettype wire

### hdl/qpst_div.sv
// Restoring divider for the speed measurement, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module qpst_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qpst_pkg::div_req_t req,
	output qpst_pkg::div_rsp_t      rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [qpst_pkg::DCNT_W-1:0]    cnt_q;
	logic [qpst_pkg::NUM_W-1:0]     num_q;
	logic [qpst_pkg::TIME_W-1:0]    rem_q;
	logic [qpst_pkg::TIME_W-1:0]    den_q;
	logic [qpst_pkg::TIME_W:0]      trial;
	logic [qpst_pkg::TIME_W:0]      diff;
	logic                           take;

	// One restoring step; a zero divisor yields an all-ones quotient
	always_comb begin
		trial = {rem_q, num_q[qpst_pkg::NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		take  = (trial >= {1'b0, den_q});
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = num_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= qpst_pkg::DCNT_W'(qpst_pkg::NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: dividend shifts out at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[qpst_pkg::NUM_W-2:0], take};
			rem_q <= take ? diff[qpst_pkg::TIME_W-1:0] : trial[qpst_pkg::TIME_W-1:0];
		end
	end

endmodule
`default_nettype wire

### hdl/qpst_core.sv
// Back part: position stepping, revolution counting, speed and averaging ring.
`timescale 1ns / 1ps
`default_nettype none
module qpst_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qpst_pkg::cfg_t     cfg,
	input  wire logic               cmd_valid,
	input  wire qpst_pkg::cmd_t     cmd,
	output logic                    cmd_pop,
	output qpst_pkg::div_req_t      div_req,
	input  wire qpst_pkg::div_rsp_t div_rsp,
	output logic                    res_push,
	output qpst_pkg::res_t          res,
	input  wire logic               res_full
);

	qpst_pkg::core_state_t           state_q;
	qpst_pkg::core_state_t           state_nx;

	logic [qpst_pkg::POS_W-1:0]      pos_q;
	logic                            lev_a_q;
	logic                            lev_b_q;
	logic                            dir_q;
	logic [qpst_pkg::REV_W-1:0]      revs_q;
	logic                            armed_q;
	logic signed [qpst_pkg::SPD_W-1:0] speed_q;
	logic [qpst_pkg::TIME_W-1:0]     rev_time_q;
	logic [qpst_pkg::TIME_W-1:0]     move_time_q;
	logic signed [qpst_pkg::SPD_W-1:0] ring_q [qpst_pkg::AVG_DEPTH];
	logic [qpst_pkg::RIDX_W-1:0]     ring_idx_q;
	logic signed [qpst_pkg::SUM_W-1:0] ring_sum_q;
	logic [qpst_pkg::TIME_W-1:0]     now_q;
	logic                            neg_q;

	logic [qpst_pkg::CPR_W-1:0]      cpr_eff;
	logic [qpst_pkg::CPR_W-1:0]      pos_ext;
	logic [qpst_pkg::CPR_W-1:0]      pos_inc;
	logic [qpst_pkg::CPR_W-1:0]      cpr_dec;
	logic                            up;
	logic [qpst_pkg::POS_W-1:0]      pos_nx;
	logic                            is_edge;
	logic                            rev_hit;
	logic                            arm_hit;
	logic                            quot_big;
	logic signed [qpst_pkg::SPD_W-1:0] mag;
	logic signed [qpst_pkg::SPD_W-1:0] spd_sat;
	logic signed [qpst_pkg::SUM_W-1:0] sum_nx;
	logic signed [qpst_pkg::SUM_W-1:0] sum_bias;
	logic signed [qpst_pkg::SUM_W-1:0] avg_full;
	logic [qpst_pkg::TIME_W-1:0]     idle_dt;
	logic                            moving;
	logic                            div_done;

	// Clamp the wrap count to 2..4096
	always_comb begin
		if (cfg.cpr < qpst_pkg::CPR_MIN) begin
			cpr_eff = qpst_pkg::CPR_MIN;
		end else if (cfg.cpr > qpst_pkg::CPR_MAX) begin
			cpr_eff = qpst_pkg::CPR_MAX;
		end else begin
			cpr_eff = cfg.cpr;
		end
	end

	// Step direction and next position
	always_comb begin
		up      = cmd.channel ? (cmd.level == lev_a_q) : (cmd.level != lev_b_q);
		pos_ext = {1'b0, pos_q};
		pos_inc = pos_ext + 1'b1;
		cpr_dec = cpr_eff - 1'b1;
		if (up) begin
			pos_nx = (pos_inc >= cpr_eff) ? '0 : pos_inc[qpst_pkg::POS_W-1:0];
		end else if (pos_q == '0 || pos_ext > cpr_eff) begin
			pos_nx = cpr_dec[qpst_pkg::POS_W-1:0];
		end else begin
			pos_nx = pos_q - 1'b1;
		end
		is_edge = (cmd.kind == qpst_pkg::K_EDGE);
		rev_hit = is_edge && (pos_nx == '0) && armed_q;
		arm_hit = is_edge && (pos_nx != '0) && (pos_nx == cfg.arm);
	end

	// Saturated signed speed from the quotient
	always_comb begin
		quot_big = |div_rsp.quot[qpst_pkg::NUM_W-1:qpst_pkg::SPD_W-1];
		mag      = {1'b0, div_rsp.quot[qpst_pkg::SPD_W-2:0]};
		if (neg_q) begin
			spd_sat = quot_big ? qpst_pkg::SPD_MIN : -mag;
		end else begin
			spd_sat = quot_big ? qpst_pkg::SPD_MAX : mag;
		end
		sum_nx = ring_sum_q + qpst_pkg::SUM_W'(spd_sat)
			- qpst_pkg::SUM_W'(ring_q[ring_idx_q]);
	end

	// Result: average truncated toward zero, idle check against this word's time
	always_comb begin
		sum_bias = ring_sum_q
			+ ((ring_sum_q < 0) ? qpst_pkg::SUM_W'(qpst_pkg::AVG_DEPTH - 1) : '0);
		avg_full = sum_bias >>> qpst_pkg::AVG_LOG2;
		idle_dt  = now_q - move_time_q;
		moving   = (idle_dt <= cfg.idle);
		res.position  = pos_q;
		res.direction = dir_q;
		res.rev_count = revs_q;
		res.speed     = speed_q;
		res.avg_speed = moving ? avg_full[qpst_pkg::SPD_W-1:0] : '0;
		res.moving    = moving;
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			qpst_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_nx = rev_hit ? qpst_pkg::ST_DIV : qpst_pkg::ST_OUT;
				end
			end
			qpst_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_nx = qpst_pkg::ST_OUT;
				end
			end
			qpst_pkg::ST_OUT: begin
				if (!res_full) begin
					state_nx = qpst_pkg::ST_IDLE;
				end
			end
			default: state_nx = qpst_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		cmd_pop          = (state_q == qpst_pkg::ST_IDLE) && cmd_valid;
		div_done         = (state_q == qpst_pkg::ST_DIV) && div_rsp.done;
		res_push         = (state_q == qpst_pkg::ST_OUT) && !res_full;
		div_req.start    = cmd_pop && rev_hit;
		div_req.dividend = {cfg.tps, 8'd0};
		div_req.divisor  = cmd.timestamp - rev_time_q;
	end

	// Tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qpst_pkg::ST_IDLE;
			pos_q       <= '0;
			lev_a_q     <= 1'b0;
			lev_b_q     <= 1'b0;
			dir_q       <= 1'b0;
			revs_q      <= '0;
			armed_q     <= 1'b0;
			speed_q     <= '0;
			rev_time_q  <= '0;
			move_time_q <= '0;
			ring_idx_q  <= '0;
			ring_sum_q  <= '0;
			now_q       <= '0;
			neg_q       <= 1'b0;
			for (int i = 0; i < qpst_pkg::AVG_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			state_q <= state_nx;
			if (cmd_pop) begin
				now_q <= cmd.timestamp;
				unique case (cmd.kind)
					qpst_pkg::K_EDGE: begin
						if (cmd.channel) begin
							lev_b_q <= cmd.level;
						end else begin
							lev_a_q <= cmd.level;
						end
						pos_q       <= pos_nx;
						dir_q       <= up;
						move_time_q <= cmd.timestamp;
						if (rev_hit) begin
							revs_q     <= up ? revs_q - 1'b1 : revs_q + 1'b1;
							neg_q      <= up;
							rev_time_q <= cmd.timestamp;
							armed_q    <= 1'b0;
						end else if (arm_hit) begin
							armed_q <= 1'b1;
						end
					end
					qpst_pkg::K_CLEAR: begin
						pos_q       <= '0;
						revs_q      <= '0;
						armed_q     <= 1'b0;
						speed_q     <= '0;
						move_time_q <= cmd.timestamp;
					end
					default: begin
					end
				endcase
			end
			// Revolution finished: store speed and update the ring
			if (div_done) begin
				speed_q            <= spd_sat;
				ring_q[ring_idx_q] <= spd_sat;
				ring_sum_q         <= sum_nx;
				ring_idx_q         <= (ring_idx_q == qpst_pkg::RIDX_W'(qpst_pkg::AVG_DEPTH - 1))
					? '0 : ring_idx_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/qpst_outq.sv
// Result queue: holds finished result words until they are popped.
`timescale 1ns / 1ps
`default_nettype none
module qpst_outq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire qpst_pkg::res_t res_in,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output qpst_pkg::res_t      res_out
);

	qpst_pkg::res_t                 ent_q [qpst_pkg::QDEPTH];
	logic [qpst_pkg::QPTR_W-1:0]    wr_q;
	logic [qpst_pkg::QPTR_W-1:0]    rd_q;
	logic [qpst_pkg::QCNT_W-1:0]    cnt_q;
	logic                           do_wr;
	logic                           do_rd;

	assign full    = (cnt_q == qpst_pkg::QCNT_W'(qpst_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign res_out = ent_q[rd_q];
	assign do_wr   = push && !full;
	assign do_rd   = pop && !empty;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= (wr_q == qpst_pkg::QPTR_W'(qpst_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_rd) begin
				rd_q <= (rd_q == qpst_pkg::QPTR_W'(qpst_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_q] <= res_in;
		end
	end

endmodule
`default_nettype wire

### hdl/quadrature_position_speed_tracker.sv
// Top level of the quadrature position and speed tracker.
`timescale 1ns / 1ps
`default_nettype none
// Each input word (encoder edge, status query or clear) yields exactly one result word.
// Words enter a two-word command queue and results leave through a two-word result
// queue, so both sides may stall independently. A query, a clear or an edge that does
// not complete a revolution goes from the idle to the output state of the executor;
// an edge that completes one first runs the bit-serial divider for the 35-bit speed
// quotient, which sets the worst-case rate. The user must write configuration registers
// through cfg_we/cfg_index/cfg_data while the block is idle; the block does not check.
module quadrature_position_speed_tracker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	output logic                                      full,
	input  wire logic [qpst_pkg::OP_W-1:0]            operation,
	input  wire logic                                 channel,
	input  wire logic                                 level,
	input  wire logic [qpst_pkg::TIME_W-1:0]          timestamp,
	output logic                                      empty,
	input  wire logic                                 pop,
	output logic [qpst_pkg::POS_W-1:0]                position,
	output logic                                      direction,
	output logic signed [qpst_pkg::REV_W-1:0]         rev_count,
	output logic signed [qpst_pkg::SPD_W-1:0]         speed,
	output logic signed [qpst_pkg::SPD_W-1:0]         avg_speed,
	output logic                                      moving,
	input  wire logic                                 cfg_we,
	input  wire logic [qpst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [qpst_pkg::CFG_DATA_W-1:0]      cfg_data
);

	qpst_pkg::cfg_t      cfg_q;
	logic                cmd_valid;
	qpst_pkg::cmd_t      cmd;
	logic                cmd_pop;
	qpst_pkg::div_req_t  div_req;
	qpst_pkg::div_rsp_t  div_rsp;
	logic                res_push;
	logic                res_full;
	qpst_pkg::res_t      res_core;
	qpst_pkg::res_t      res_out;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cpr  <= qpst_pkg::CPR_RST;
			cfg_q.arm  <= qpst_pkg::ARM_RST;
			cfg_q.tps  <= qpst_pkg::TPS_RST;
			cfg_q.idle <= qpst_pkg::IDLE_RST;
		end else if (cfg_we) begin
			unique case (qpst_pkg::cfg_idx_t'(cfg_index))
				qpst_pkg::CFG_CPR:  cfg_q.cpr  <= cfg_data[qpst_pkg::CPR_W-1:0];
				qpst_pkg::CFG_ARM:  cfg_q.arm  <= cfg_data[qpst_pkg::ARM_W-1:0];
				qpst_pkg::CFG_TPS:  cfg_q.tps  <= cfg_data[qpst_pkg::TPS_W-1:0];
				qpst_pkg::CFG_IDLE: cfg_q.idle <= cfg_data[qpst_pkg::TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	qpst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.operation (operation),
		.channel   (channel),
		.level     (level),
		.timestamp (timestamp),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	qpst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	qpst_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res_push  (res_push),
		.res       (res_core),
		.res_full  (res_full)
	);

	qpst_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.res_in  (res_core),
		.full    (res_full),
		.pop     (pop),
		.empty   (empty),
		.res_out (res_out)
	);

	// Result word fields
	assign position  = res_out.position;
	assign direction = res_out.direction;
	assign rev_count = res_out.rev_count;
	assign speed     = res_out.speed;
	assign avg_speed = res_out.avg_speed;
	assign moving    = res_out.moving;

`ifndef NO_ASSERTIONS
	// The executor never pushes a result into a full result queue
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && res_full))
		else $error("result pushed into full queue");

	// A division is never started while the divider is still busy
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	// Divider completion is a single-cycle pulse
	a_div_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |=> !div_rsp.done)
		else $error("divider done held high");

	// A started division reports busy in the next cycle
	a_div_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> div_rsp.busy)
		else $error("divider not busy after start");
`endif

endmodule
`default_nettype wire
